>>> rtl/tga_pixel_stream_decoder_unit_macros.svh
// Assertion macros used by the TGA pixel stream decoder unit.
`ifndef TGA_PIXEL_STREAM_DECODER_UNIT_MACROS_SVH
`define TGA_PIXEL_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define TPSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpsd assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define TPSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpsd assertion failed");

`endif

>>> rtl/tpsd_pkg.sv
// Package with the shared widths, constants and register indexes of the TGA decoder.
package tpsd_pkg;

  localparam int INDEX_WIDTH = 24;

  localparam int COUNT_W = 25;
  localparam int BYTE_W  = 8;
  localparam int PIXEL_W = 32;
  localparam int REP_W   = 8;
  localparam int START_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] INDEX_MASK =
    COUNT_W'((64'd1 << INDEX_WIDTH) - 64'd1);

  localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h7f;
  localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_COUNT = 2'd0,
    REG_RLE_MODE    = 2'd1,
    REG_DEPTH_IS_32 = 2'd2
  } cfg_reg_t;

endpackage

>>> rtl/tpsd_in_if.sv
// Input channel interface: one pixel-data byte per item.
interface tpsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpsd_pkg::BYTE_W-1:0]   data_byte;
  logic                          image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

>>> rtl/tpsd_out_if.sv
// Result channel interface: one pixel value with its repeat count and index per item.
interface tpsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [tpsd_pkg::PIXEL_W-1:0]  pixel;
  logic [tpsd_pkg::REP_W-1:0]    repeat_res;
  logic [tpsd_pkg::START_W-1:0]  start_index;
  logic                          last;

  modport source (output valid, output pixel, output repeat_res, output start_index,
                  output last, input ready);
  modport sink   (input valid, input pixel, input repeat_res, input start_index,
                  input last, output ready);
endinterface

>>> rtl/tga_pixel_stream_decoder_unit.sv
// Top level of the TGA pixel stream decoder: byte stream in, pixel runs out.
// A result passes the input register, then the result register, to reach out_ch.
// Throughput: one byte item per cycle; a byte that completes a pixel stalls while
// a result waits on out_ch, but a byte that completes no pixel moves on even then.
// Reset (rst_n low, synchronous) sets pixel_count to 1, both mode bits to 0,
// clears both pipeline registers and leaves the decoder waiting for a packet header.
`include "tga_pixel_stream_decoder_unit_macros.svh"

module tga_pixel_stream_decoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  tpsd_in_if.sink                             in_ch,
  tpsd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [tpsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpsd_pkg::COUNT_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [tpsd_pkg::COUNT_W-1:0] pix_count_r;
  logic                         rle_mode_r;
  logic                         depth32_r;

  // Input register stage.
  logic                         in_valid_r;
  logic [tpsd_pkg::BYTE_W-1:0]  byte_r;
  logic                         start_r;

  // Decoder state.
  logic                         exp_hdr_r,   exp_hdr_nxt;
  logic                         run_pkt_r,   run_pkt_nxt;
  logic [7:0]                   pkt_left_r,  pkt_left_nxt;
  logic [1:0]                   bip_r,       bip_nxt;
  logic [23:0]                  partial_r,   partial_nxt;
  logic [tpsd_pkg::COUNT_W-1:0] done_cnt_r,  done_cnt_nxt;
  logic                         img_fin_r,   img_fin_nxt;

  // Result register.
  logic                         out_valid_r;
  logic [tpsd_pkg::PIXEL_W-1:0] out_pixel_r, out_pixel_nxt;
  logic [tpsd_pkg::REP_W-1:0]   out_rep_r,   out_rep_nxt;
  logic [tpsd_pkg::START_W-1:0] out_start_r, out_start_nxt;
  logic                         out_last_r,  out_last_nxt;

  logic has_result;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  // The item in the input register leaves when it produces nothing or the
  // result register is free (empty, or being drained this cycle).
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = in_valid_r && (!has_result || out_free);
  assign in_ch.ready = !in_valid_r || s1_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_count_r <= tpsd_pkg::COUNT_W'(1);
      rle_mode_r  <= 1'b0;
      depth32_r   <= 1'b0;
    end else if (cfg_we) begin
      case (tpsd_pkg::cfg_reg_t'(cfg_index))
        tpsd_pkg::REG_PIXEL_COUNT: pix_count_r <= cfg_wdata;
        tpsd_pkg::REG_RLE_MODE:    rle_mode_r  <= cfg_wdata[0];
        tpsd_pkg::REG_DEPTH_IS_32: depth32_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r  <= in_ch.data_byte;
      start_r <= in_ch.image_start;
    end
  end

  // Decode pass: every decision for one byte is made here.
  always_comb begin
    logic                         c_exp_hdr;
    logic                         c_run_pkt;
    logic [7:0]                   c_pkt_left;
    logic [1:0]                   c_bip;
    logic [23:0]                  c_partial;
    logic [tpsd_pkg::COUNT_W-1:0] c_done;
    logic                         c_fin;
    logic                         complete;
    logic [tpsd_pkg::COUNT_W-1:0] remaining;
    logic [7:0]                   rep;
    logic [7:0]                   left_dec;

    // An image_start byte sees the cleared state.
    c_exp_hdr  = start_r ? 1'b1 : exp_hdr_r;
    c_run_pkt  = start_r ? 1'b0 : run_pkt_r;
    c_pkt_left = start_r ? 8'd0 : pkt_left_r;
    c_bip      = start_r ? 2'd0 : bip_r;
    c_partial  = start_r ? 24'd0 : partial_r;
    c_done     = start_r ? '0 : done_cnt_r;
    c_fin      = start_r ? 1'b0 : img_fin_r;

    exp_hdr_nxt  = c_exp_hdr;
    run_pkt_nxt  = c_run_pkt;
    pkt_left_nxt = c_pkt_left;
    bip_nxt      = c_bip;
    partial_nxt  = c_partial;
    done_cnt_nxt = c_done;
    img_fin_nxt  = c_fin;
    has_result   = 1'b0;

    complete  = (c_bip == 2'd3) || ((c_bip == 2'd2) && !depth32_r);
    remaining = pix_count_r - c_done;
    left_dec  = (c_pkt_left != 8'd0) ? (c_pkt_left - 8'd1) : 8'd0;

    rep = 8'd1;
    if (rle_mode_r && c_run_pkt) begin
      rep = (c_pkt_left == 8'd0) ? 8'd1 : c_pkt_left;
    end
    if ({{(tpsd_pkg::COUNT_W-8){1'b0}}, rep} > remaining) begin
      rep = remaining[7:0];
    end

    out_pixel_nxt = {tpsd_pkg::OPAQUE_ALPHA, c_partial};
    if (c_bip == 2'd2) begin
      out_pixel_nxt[23:16] = byte_r;
    end
    if (depth32_r && (c_bip == 2'd3)) begin
      out_pixel_nxt[31:24] = byte_r;
    end
    out_rep_nxt   = rep;
    out_start_nxt = tpsd_pkg::START_W'(c_done & tpsd_pkg::INDEX_MASK);
    out_last_nxt  = (c_done + {{(tpsd_pkg::COUNT_W-8){1'b0}}, rep}) >= pix_count_r;

    if (c_fin || (c_done >= pix_count_r)) begin
      // Image complete or empty: the byte is dropped.
    end else if (rle_mode_r && c_exp_hdr) begin
      run_pkt_nxt  = byte_r[7];
      pkt_left_nxt = (byte_r & tpsd_pkg::COUNT_MASK) + 8'd1;
      exp_hdr_nxt  = 1'b0;
    end else if (!complete) begin
      case (c_bip)
        2'd0:    partial_nxt[7:0]   = byte_r;
        2'd1:    partial_nxt[15:8]  = byte_r;
        default: partial_nxt[23:16] = byte_r;
      endcase
      bip_nxt = c_bip + 2'd1;
    end else begin
      has_result  = 1'b1;
      bip_nxt     = 2'd0;
      partial_nxt = 24'd0;
      if (rle_mode_r) begin
        if (c_run_pkt) begin
          pkt_left_nxt = 8'd0;
          exp_hdr_nxt  = 1'b1;
        end else begin
          pkt_left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            exp_hdr_nxt = 1'b1;
          end
        end
      end
      done_cnt_nxt = c_done + {{(tpsd_pkg::COUNT_W-8){1'b0}}, rep};
      img_fin_nxt  = out_last_nxt;
    end
  end

  // Decoder state advances only when the registered byte moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_hdr_r  <= 1'b1;
      run_pkt_r  <= 1'b0;
      pkt_left_r <= 8'd0;
      bip_r      <= 2'd0;
      partial_r  <= 24'd0;
      done_cnt_r <= '0;
      img_fin_r  <= 1'b0;
    end else if (s1_fire) begin
      exp_hdr_r  <= exp_hdr_nxt;
      run_pkt_r  <= run_pkt_nxt;
      pkt_left_r <= pkt_left_nxt;
      bip_r      <= bip_nxt;
      partial_r  <= partial_nxt;
      done_cnt_r <= done_cnt_nxt;
      img_fin_r  <= img_fin_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && has_result) begin
      out_pixel_r <= out_pixel_nxt;
      out_rep_r   <= out_rep_nxt;
      out_start_r <= out_start_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel       = out_pixel_r;
  assign out_ch.repeat_res  = out_rep_r;
  assign out_ch.start_index = out_start_r;
  assign out_ch.last        = out_last_r;

  // A result always covers at least one pixel.
  `TPSD_ASSERT_NOW(a_rep_nonzero, out_valid_r, out_rep_r != 8'd0)
  // A packet never holds more than 128 pixels.
  `TPSD_ASSERT_NOW(a_pkt_bound, 1'b1, pkt_left_r <= 8'd128)
  // A byte that stalls in the input register stays there.
  `TPSD_ASSERT_NEXT(a_s1_hold, in_valid_r && !s1_fire, in_valid_r)
  // A byte that finishes a pixel lands in the result register.
  `TPSD_ASSERT_NEXT(a_result_lands, s1_fire && has_result, out_valid_r)

endmodule

>>> verif/tpsd_run_checker.sv
// Checker that predicts the decoded pixel runs from the byte stream and compares results.
module tpsd_run_checker
  import tpsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tpsd_in_if                   in_ch,
  tpsd_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  output int                   mismatches,
  output int                   runs_pending
);

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic [REP_W-1:0]   repeat_res;
    logic [START_W-1:0] start_index;
    logic               last;
  } pixel_run_t;

  pixel_run_t expected_runs[$];
  int fail_count = 0;
  int queued = 0;

  // Configuration copy.
  logic [COUNT_W-1:0] px_count;
  logic               rle_on;
  logic               wide_px;

  // Decoder state copy.
  logic               want_header;
  logic               run_pkt;
  logic [7:0]         pkt_left;
  logic [1:0]         byte_pos;
  logic [23:0]        partial_px;
  logic [COUNT_W-1:0] px_done;
  logic               img_done;

  assign mismatches   = fail_count;
  assign runs_pending = queued;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_decoder();
    want_header = 1'b1;
    run_pkt     = 1'b0;
    pkt_left    = '0;
    byte_pos    = '0;
    partial_px  = '0;
    px_done     = '0;
    img_done    = 1'b0;
  endtask

  // Advances the decoder by one byte and queues the run it finishes, if any.
  task automatic decode_byte(input logic [7:0] b, input logic restart);
    logic               completes;
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] rep;
    pixel_run_t         run;
    if (restart) clear_decoder();
    if (img_done || px_done >= px_count) return;
    if (rle_on && want_header) begin
      run_pkt     = b[7];
      pkt_left    = {1'b0, b[6:0]} + 8'd1;
      want_header = 1'b0;
      return;
    end
    completes = (byte_pos == 2'd3) || (byte_pos == 2'd2 && !wide_px);
    if (!completes) begin
      partial_px = partial_px | (24'(b) << (8 * byte_pos));
      byte_pos   = byte_pos + 2'd1;
      return;
    end
    if (byte_pos == 2'd2) partial_px = partial_px | (24'(b) << 16);
    run.pixel = {(wide_px && byte_pos == 2'd3) ? b : OPAQUE_ALPHA, partial_px};
    byte_pos   = '0;
    partial_px = '0;
    remaining = px_count - px_done;
    rep = COUNT_W'(1);
    if (rle_on) begin
      if (run_pkt) begin
        rep = (pkt_left == 8'd0) ? COUNT_W'(1) : COUNT_W'(pkt_left);
        pkt_left    = '0;
        want_header = 1'b1;
      end else begin
        if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
        if (pkt_left == 8'd0) want_header = 1'b1;
      end
    end
    // A run that would pass the end of the image is cut short.
    if (rep > remaining) rep = remaining;
    run.repeat_res  = rep[REP_W-1:0];
    run.start_index = START_W'(px_done & INDEX_MASK);
    px_done = px_done + rep;
    if (px_done >= px_count) img_done = 1'b1;
    run.last = img_done;
    expected_runs.push_back(run);
  endtask

  always @(posedge clk) begin : watch
    pixel_run_t want;
    if (!rst_n) begin
      px_count = COUNT_W'(1);
      rle_on   = 1'b0;
      wide_px  = 1'b0;
      clear_decoder();
      expected_runs.delete();
    end else begin
      // Results are retired before new bytes are taken, since a byte never
      // produces its result in the cycle that it is accepted.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel %h", out_ch.pixel));
        end else begin
          want = expected_runs.pop_front();
          if (out_ch.pixel !== want.pixel)
            report_mismatch($sformatf("pixel %h, expected %h at index %0d",
                                      out_ch.pixel, want.pixel, want.start_index));
          if (out_ch.repeat_res !== want.repeat_res)
            report_mismatch($sformatf("repeat %0d, expected %0d at index %0d",
                                      out_ch.repeat_res, want.repeat_res, want.start_index));
          if (out_ch.start_index !== want.start_index)
            report_mismatch($sformatf("start index %0d, expected %0d",
                                      out_ch.start_index, want.start_index));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b at index %0d",
                                      out_ch.last, want.last, want.start_index));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PIXEL_COUNT: px_count = cfg_wdata;
          REG_RLE_MODE:    rle_on   = cfg_wdata[0];
          REG_DEPTH_IS_32: wide_px  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.image_start);
    end
    queued <= expected_runs.size();
  end

endmodule

>>> verif/tb.sv
// Testbench top for the TGA pixel stream decoder: stimulus, idling and the verdict.
module tb;
  import tpsd_pkg::*;

  // The slowest correct run stays far below this: roughly 1200 bytes, each
  // with random idling on either side, plus at times a drain and an
  // update of all three configuration registers between images.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int IDLE_PCT     = 32;
  localparam int RANDOM_BYTES = 1100;
  // Results pass through the input and result registers after their last byte,
  // so a short pause after the last expected result makes sure nothing is still in flight.
  localparam int DRAIN_CYCLES = 4;
  localparam logic [COUNT_W-1:0] MAX_PIXELS = 25'd16777216;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_wdata;
  int                   mismatches;
  int                   runs_pending;
  int                   cycle_count = 0;

  // When calm is set neither side idles; the random part holds it for a while.
  bit                   calm;
  // Set before the first byte of an image so that it carries image_start.
  bit                   open_image;
  // Shadow of the configuration that the testbench last wrote.
  logic [COUNT_W-1:0]   cur_count;
  bit                   cur_rle;
  bit                   cur_d32;
  // Bytes still allowed in a truncated image; negative means no limit.
  int                   budget;
  // Bytes sent so far by the random part, counted against RANDOM_BYTES.
  int                   useful;

  tpsd_in_if  in_ch ();
  tpsd_out_if out_ch ();

  tga_pixel_stream_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tpsd_run_checker run_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .runs_pending (runs_pending)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offers one byte, with random idle cycles ahead of it, and returns at the
  // edge where it is taken. Valid stays high so back-to-back bytes flow.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.image_start <= open_image;
    open_image = 1'b0;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sends the low n bytes of a word, least significant byte first.
  task automatic send_bytes(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) send_byte(w[8*i +: 8]);
  endtask

  // Sends one byte of a well-formed image unless the truncation budget is spent.
  task automatic feed(input logic [7:0] b);
    if (budget == 0) return;
    send_byte(b);
    useful++;
    if (budget > 0) budget--;
  endtask

  // Stops the stream and waits until every expected result has arrived and
  // the pipeline has had time to empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic configure(input logic [COUNT_W-1:0] count, input bit rle, input bit d32);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIXEL_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_index <= REG_RLE_MODE;
    cfg_wdata <= COUNT_W'(rle);
    @(posedge clk);
    cfg_index <= REG_DEPTH_IS_32;
    cfg_wdata <= COUNT_W'(d32);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_count = count;
    cur_rle   = rle;
    cur_d32   = d32;
  endtask

  // Streams one image under the current configuration. In run-length mode
  // the packets have random kinds and counts, some passing the end of the
  // image. A truncated image stops after a random number of bytes, often in
  // the middle of a packet or a pixel, and the next image start abandons it.
  task automatic stream_image(input bit cut);
    int left;
    int cnt;
    int bpp;
    bit run;
    bpp = cur_d32 ? 4 : 3;
    budget = cut ? $urandom_range(1, 40) : -1;
    left = int'(cur_count);
    open_image = 1'b1;
    while (left > 0 && budget != 0) begin
      cnt = 1;
      if (cur_rle) begin
        run = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       cnt = 128;
          1:       cnt = left + $urandom_range(1, 3);
          default: cnt = $urandom_range(1, (left < 16) ? left : 16);
        endcase
        if (cnt > 128) cnt = 128;
        // Raw packets carry every pixel, so they are kept short.
        if (!run && cnt > 12) cnt = $urandom_range(1, 12);
        feed({run, 7'(cnt - 1)});
        repeat (run ? bpp : cnt * bpp) feed(8'($urandom_range(255)));
      end else begin
        repeat (bpp) feed(8'($urandom_range(255)));
      end
      left -= cnt;
    end
    // Bytes past the last pixel must be ignored.
    if (!cut && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int pick;
    logic [COUNT_W-1:0] count;
    bit rle;
    bit d32;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.image_start <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PIXEL_COUNT;
    cfg_wdata         <= '0;
    calm       = 1'b0;
    open_image = 1'b0;
    cur_count  = COUNT_W'(1);
    cur_rle    = 1'b0;
    cur_d32    = 1'b0;
    budget     = -1;
    useful     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: a single 24-bit pixel gets an opaque alpha and
    // ends the image; the byte after it is ignored.
    open_image = 1'b1;
    send_bytes(32'h0000_0000, 3);
    send_byte(8'hff);

    // All-ones and all-zero 32-bit pixels, alpha taken from the stream.
    settle();
    configure(COUNT_W'(2), 1'b0, 1'b1);
    open_image = 1'b1;
    send_bytes(32'hffff_ffff, 4);
    send_bytes(32'h0000_0000, 4);

    // Depth switched in the middle of a pixel: three bytes in 32-bit mode,
    // then a fourth byte in 24-bit mode completes it with opaque alpha.
    // Next, two bytes in 24-bit mode and a switch to 32-bit mode make the
    // pixel take two more bytes, the last one as alpha.
    settle();
    configure(COUNT_W'(3), 1'b0, 1'b1);
    open_image = 1'b1;
    send_bytes(32'h0033_2211, 3);
    settle();
    configure(COUNT_W'(3), 1'b0, 1'b0);
    send_byte(8'h44);
    send_bytes(32'h0000_6655, 2);
    settle();
    configure(COUNT_W'(3), 1'b0, 1'b1);
    send_bytes(32'h0000_8877, 2);

    // Run-length packets: a run of two, a raw single pixel, then the longest
    // run, which is cut to the two pixels left. A trailing byte is ignored.
    settle();
    configure(COUNT_W'(5), 1'b1, 1'b0);
    open_image = 1'b1;
    send_bytes(32'hc3b2_a181, 4);
    send_bytes(32'hf6e5_d400, 4);
    send_bytes(32'h0302_01ff, 4);
    send_byte(8'h5a);

    // A run header taken in run-length mode is held, unused, while the mode
    // is off, and governs the next pixel once the mode is back on.
    settle();
    configure(COUNT_W'(4), 1'b1, 1'b0);
    open_image = 1'b1;
    send_byte(8'h81);
    settle();
    configure(COUNT_W'(4), 1'b0, 1'b0);
    send_bytes(32'h000c_0b0a, 3);
    settle();
    configure(COUNT_W'(4), 1'b1, 1'b0);
    send_bytes(32'h000f_0e0d, 3);

    // A zero pixel count accepts no pixel at all.
    settle();
    configure(COUNT_W'(0), 1'b0, 1'b0);
    open_image = 1'b1;
    send_bytes(32'h0056_3412, 3);

    // The largest image: a full run from index zero.
    settle();
    configure(MAX_PIXELS, 1'b1, 1'b1);
    open_image = 1'b1;
    send_byte(8'hff);
    send_bytes(32'h4030_2010, 4);

    // Random images. Most are well formed; some are truncated, some are
    // plain noise with random image starts. Images often follow each other
    // without a drain, so an image start can arrive while results are
    // still waiting on the output.
    while (useful < RANDOM_BYTES) begin
      calm = (useful >= 400 && useful < 600);
      if ($urandom_range(99) < 60) begin
        settle();
        rle  = 1'($urandom_range(1));
        d32  = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 5)
          count = COUNT_W'(1);
        else if (pick < 9)
          count = MAX_PIXELS;
        else if (pick < 70)
          count = COUNT_W'($urandom_range(2, 24));
        else
          count = rle ? COUNT_W'($urandom_range(25, 400)) : COUNT_W'($urandom_range(25, 60));
        configure(count, rle, d32);
      end
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 12)) begin
          open_image = 1'($urandom_range(1));
          send_byte(8'($urandom_range(255)));
          useful++;
        end
      end else begin
        stream_image(($urandom_range(99) < 15) || (cur_count > 5000));
      end
    end

    settle();
    if (mismatches == 0 && runs_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/tpsd_pkg.sv
rtl/tpsd_in_if.sv
rtl/tpsd_out_if.sv
rtl/tga_pixel_stream_decoder_unit.sv
verif/tpsd_run_checker.sv
verif/tb.sv
